[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/frba_pkg.sv]
`default_nettype none

package frba_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_GRANT    = 3'd0,
        ST_WAITED   = 3'd1,
        ST_SUBMIT   = 3'd2,
        ST_OVERSIZE = 3'd3,
        ST_OVERRUN  = 3'd4
    } t_status;

    // What a fence cell loads this cycle
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_NEXT = 2'd1,
        CELL_HEAD = 2'd2,
        CELL_LOAD = 2'd3
    } t_cell_op;

    localparam int unsigned FENCE_W = 64;
    localparam int unsigned ALIGN_W = 9;

    // Highest set bit of the alignment; zero acts as one
    function automatic logic [ALIGN_W-1:0] eff_align(input logic [ALIGN_W-1:0] a);
        logic [ALIGN_W-1:0] p;
        p = ALIGN_W'(1);
        for (int i = 0; i < ALIGN_W; i++) begin
            if (a[i]) begin
                p = ALIGN_W'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/frba_cell.sv]
`default_nettype none

// One fence queue entry: holds a fence id and its offset, takes its
// neighbor's entry on a shift, the head entry on a rotate, or new data.
module frba_cell #(
    parameter int unsigned OB = 25
) (
    input  wire                          i_clk,
    input  frba_pkg::t_cell_op           i_op,
    input  wire [frba_pkg::FENCE_W-1:0]  i_nbr_id,
    input  wire [OB-1:0]                 i_nbr_off,
    input  wire [frba_pkg::FENCE_W-1:0]  i_head_id,
    input  wire [OB-1:0]                 i_head_off,
    input  wire [frba_pkg::FENCE_W-1:0]  i_ld_id,
    input  wire [OB-1:0]                 i_ld_off,
    output logic [frba_pkg::FENCE_W-1:0] o_id,
    output logic [OB-1:0]                o_off
);
    import frba_pkg::*;

    logic [FENCE_W-1:0] r_id;
    logic [OB-1:0]      r_off;
    logic [FENCE_W-1:0] n_id;
    logic [OB-1:0]      n_off;

    // entry select
    always_comb begin
        unique case (i_op)
            CELL_NEXT: begin
                n_id  = i_nbr_id;
                n_off = i_nbr_off;
            end
            CELL_HEAD: begin
                n_id  = i_head_id;
                n_off = i_head_off;
            end
            CELL_LOAD: begin
                n_id  = i_ld_id;
                n_off = i_ld_off;
            end
            default: begin
                n_id  = r_id;
                n_off = r_off;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_off <= n_off;
    end

    assign o_id  = r_id;
    assign o_off = r_off;

endmodule

`default_nettype wire

[hw/rtl/fenced_ring_buffer_allocator.sv]
`default_nettype none

// Fenced ring-buffer space allocator.
// Input stream: tuser carries the action (0 reserve, 1 commit); tdata carries
// request_bytes, alignment, completed_fence, current_fence from bit 0 up.
// Output stream: one result per input; tuser carries status and
// fence_merged, tdata carries write_offset, free_space, wait_fence.
// Config channel: a write of buffer_size (0 taken as 1, large values
// saturated to 2^(OFFSET_BITS-1)) also empties the allocator.
// One item is worked at a time. A commit passes through S_COMMIT and S_DONE.
// A reserve goes to S_CHECK, where an oversize one goes to S_DONE; the rest
// retire covered fences in S_RETIRE, then in S_ALLOC a fitting grant goes
// through S_FINISH, one that wraps to zero to S_DONE, and else S_SEARCH
// examines fence entries, with S_RESTORE rotating the rest of the queue back
// to order on must-submit. The fence queue is a chain of cells handling one
// entry per cycle at its head cell.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the engine only at its next result.
// Reset (synchronous, active low) empties the ring and queue and sets
// buffer_size to 65536.
module fenced_ring_buffer_allocator #(
    parameter int unsigned FENCE_DEPTH = 16,
    parameter int unsigned OFFSET_BITS = 25
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // config write
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [OFFSET_BITS-1:0] i_cfg_data,
    // request stream
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // request_bytes, alignment, completed_fence, current_fence
    input  wire [((OFFSET_BITS+137+7)/8)*8-1:0] i_s_axis_tdata,
    // action
    input  wire                   i_s_axis_tuser,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // write_offset, free_space, wait_fence
    output logic [((2*OFFSET_BITS+64+7)/8)*8-1:0] o_m_axis_tdata,
    // status, fence_merged
    output logic [3:0]            o_m_axis_tuser
);
    import frba_pkg::*;

    localparam int unsigned OB     = OFFSET_BITS;
    localparam int unsigned W1     = OB + 1;
    localparam int unsigned D      = FENCE_DEPTH;
    localparam int unsigned CW     = $clog2(D + 1);
    localparam int unsigned IW     = $clog2(D);
    localparam int unsigned DW_OUT = ((2*OB+64+7)/8)*8;
    localparam logic [OB-1:0] SIZE_MAX   = OB'(1) << (OB - 1);
    localparam logic [OB-1:0] SIZE_RESET = OB'(65536);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CHECK   = 9'b000000010,
        S_RETIRE  = 9'b000000100,
        S_ALLOC   = 9'b000001000,
        S_SEARCH  = 9'b000010000,
        S_RESTORE = 9'b000100000,
        S_FINISH  = 9'b001000000,
        S_COMMIT  = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        FM_END    = 2'd0,
        FM_BEHIND = 2'd1,
        FM_WAITED = 2'd2
    } t_fmode;

    typedef enum logic [1:0] {
        CH_HOLD = 2'd0,
        CH_POP  = 2'd1,
        CH_ROT  = 2'd2,
        CH_LOAD = 2'd3
    } t_chain;

    // control state
    t_state         r_state, n_state;
    logic [OB-1:0]  r_bsize, n_bsize;
    logic [OB-1:0]  r_wp, n_wp;
    logic [OB-1:0]  r_sl, n_sl;
    logic [OB-1:0]  r_cp, n_cp;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_k, n_k;
    logic           r_any, n_any;
    logic           r_mvalid, n_mvalid;
    // item payload
    logic           r_action, n_action;
    logic [OB-1:0]  r_bytes, n_bytes;
    logic [ALIGN_W-1:0] r_align, n_align;
    logic [W1-1:0]  r_need, n_need;
    logic [FENCE_W-1:0] r_done, n_done;
    logic [FENCE_W-1:0] r_cur, n_cur;
    t_status        r_status, n_status;
    logic [FENCE_W-1:0] r_fence, n_fence;
    logic           r_merged, n_merged;
    t_fmode         r_fmode, n_fmode;
    // output register
    t_status        r_o_status, n_o_status;
    logic           r_o_merged, n_o_merged;
    logic [OB-1:0]  r_o_wp, n_o_wp;
    logic [OB-1:0]  r_o_sl, n_o_sl;
    logic [FENCE_W-1:0] r_o_fence, n_o_fence;

    // fence chain
    t_chain             w_chain;
    logic [IW-1:0]      w_lsel;
    logic [FENCE_W-1:0] w_id  [D];
    logic [OB-1:0]      w_off [D];
    t_cell_op           w_op  [D];
    logic [CW-1:0]      w_last;

    logic [FENCE_W-1:0] w_in_done, w_in_cur;
    logic [ALIGN_W-1:0] w_in_align;
    logic [OB-1:0]      w_in_bytes;
    logic [W1-1:0]      w_al, w_diff, w_sum, w_bs1, w_wp1, w_cp1, w_gp1;
    logic               w_out_free;

    assign w_in_bytes = i_s_axis_tdata[OB-1:0];
    assign w_in_align = i_s_axis_tdata[OB+ALIGN_W-1:OB];
    assign w_in_done  = i_s_axis_tdata[OB+ALIGN_W+FENCE_W-1:OB+ALIGN_W];
    assign w_in_cur   = i_s_axis_tdata[OB+ALIGN_W+2*FENCE_W-1:OB+ALIGN_W+FENCE_W];

    assign w_last = r_count - CW'(1);
    assign w_bs1  = {1'b0, r_bsize};
    assign w_wp1  = {1'b0, r_wp};
    assign w_cp1  = {1'b0, r_cp};
    assign w_gp1  = {1'b0, w_off[0]};
    assign w_al   = (w_wp1 + W1'(r_align) - W1'(1)) & ~(W1'(r_align) - W1'(1));
    assign w_diff = w_al - w_wp1;
    assign w_sum  = w_wp1 + {1'b0, r_bytes};
    assign w_out_free = !r_mvalid || i_m_axis_tready;

    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_bsize  = r_bsize;
        n_wp     = r_wp;
        n_sl     = r_sl;
        n_cp     = r_cp;
        n_count  = r_count;
        n_k      = r_k;
        n_any    = r_any;
        n_mvalid = r_mvalid;
        n_action = r_action;
        n_bytes  = r_bytes;
        n_align  = r_align;
        n_need   = r_need;
        n_done   = r_done;
        n_cur    = r_cur;
        n_status = r_status;
        n_fence  = r_fence;
        n_merged = r_merged;
        n_fmode  = r_fmode;
        n_o_status = r_o_status;
        n_o_merged = r_o_merged;
        n_o_wp     = r_o_wp;
        n_o_sl     = r_o_sl;
        n_o_fence  = r_o_fence;
        w_chain  = CH_HOLD;
        w_lsel   = IW'(r_count);

        if (r_mvalid && i_m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (i_cfg_data == '0) begin
                        n_bsize = OB'(1);
                    end else if (i_cfg_data > SIZE_MAX) begin
                        n_bsize = SIZE_MAX;
                    end else begin
                        n_bsize = i_cfg_data;
                    end
                    n_wp    = '0;
                    n_sl    = '0;
                    n_cp    = '0;
                    n_count = '0;
                end else if (i_s_axis_tvalid) begin
                    n_action = i_s_axis_tuser;
                    n_bytes  = w_in_bytes;
                    n_align  = eff_align(w_in_align);
                    n_need   = {1'b0, w_in_bytes} + W1'(eff_align(w_in_align));
                    n_done   = w_in_done;
                    n_cur    = w_in_cur;
                    n_fence  = '0;
                    n_merged = 1'b0;
                    n_any    = 1'b0;
                    n_k      = '0;
                    n_status = ST_GRANT;
                    n_state  = i_s_axis_tuser ? S_COMMIT : S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_need > w_bs1) begin
                    n_status = ST_OVERSIZE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_RETIRE;
                end
            end
            // retire one covered fence per cycle from the head cell
            S_RETIRE: begin
                if (r_count != '0 && r_done >= w_id[0]) begin
                    n_cp    = w_off[0];
                    n_count = r_count - CW'(1);
                    n_any   = 1'b1;
                    w_chain = CH_POP;
                end else begin
                    if (r_any && r_wp == r_cp) begin
                        n_wp = '0;
                        n_cp = '0;
                        n_sl = r_bsize;
                    end
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (r_wp >= r_cp && r_need <= w_bs1 - w_wp1) begin
                    n_fmode = FM_END;
                    n_state = S_FINISH;
                end else if (r_wp >= r_cp && r_need < w_cp1) begin
                    n_wp    = '0;
                    n_sl    = r_cp - OB'(1);
                    n_state = S_DONE;
                end else if (r_wp < r_cp && r_need < w_cp1 - w_wp1) begin
                    n_fmode = FM_BEHIND;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            // examine the head entry; on a miss, rotate the queue by one
            S_SEARCH: begin
                if (r_k == r_count) begin
                    n_status = ST_SUBMIT;
                    n_state  = S_DONE;
                end else begin
                    logic hit;
                    logic all;
                    logic [OB-1:0] no, ns, ng;
                    hit = 1'b0;
                    all = 1'b0;
                    no  = '0;
                    ns  = '0;
                    ng  = '0;
                    if (r_wp == w_off[0]) begin
                        hit = 1'b1;
                        all = 1'b1;
                        ns  = r_bsize;
                    end else if (r_wp > w_off[0]) begin
                        if (w_bs1 - w_wp1 >= r_need) begin
                            hit = 1'b1;
                            no  = r_wp;
                            ns  = r_bsize - r_wp;
                            ng  = w_off[0];
                        end else if (w_gp1 > r_need) begin
                            hit = 1'b1;
                            ns  = w_off[0] - OB'(1);
                            ng  = w_off[0];
                        end
                    end else if (w_gp1 - w_wp1 > r_need) begin
                        hit = 1'b1;
                        no  = r_wp;
                        ns  = w_off[0] - r_wp - OB'(1);
                        ng  = w_off[0];
                    end
                    if (!hit) begin
                        w_chain = CH_ROT;
                        n_k     = r_k + CW'(1);
                    end else if (w_id[0] == r_cur) begin
                        n_status = ST_SUBMIT;
                        n_state  = S_RESTORE;
                    end else begin
                        n_fence  = w_id[0];
                        n_count  = all ? '0 : (r_count - r_k - CW'(1));
                        w_chain  = CH_POP;
                        n_wp     = no;
                        n_sl     = ns;
                        n_cp     = ng;
                        n_status = ST_WAITED;
                        n_fmode  = FM_WAITED;
                        n_state  = S_FINISH;
                    end
                end
            end
            // rotate the rest of the queue back into original order
            S_RESTORE: begin
                if (r_k == r_count) begin
                    n_state = S_DONE;
                end else begin
                    w_chain = CH_ROT;
                    n_k     = r_k + CW'(1);
                end
            end
            S_FINISH: begin
                n_wp = w_al[OB-1:0];
                unique case (r_fmode)
                    FM_END:    n_sl = OB'(w_bs1 - w_al);
                    FM_BEHIND: n_sl = OB'(w_cp1 - w_al - W1'(1));
                    default:   n_sl = ({1'b0, r_sl} >= w_diff) ?
                                      OB'({1'b0, r_sl} - w_diff) : '0;
                endcase
                n_state = S_DONE;
            end
            S_COMMIT: begin
                if (w_sum > w_bs1 || r_bytes > r_sl) begin
                    n_status = ST_OVERRUN;
                end else begin
                    n_wp    = w_sum[OB-1:0];
                    n_sl    = r_sl - r_bytes;
                    w_chain = CH_LOAD;
                    if (r_count != '0 && w_id[IW'(w_last)] == r_cur) begin
                        w_lsel = IW'(w_last);
                    end else if (r_count != '0 && r_count >= CW'(D)) begin
                        w_lsel   = IW'(w_last);
                        n_merged = 1'b1;
                    end else begin
                        w_lsel  = IW'(r_count);
                        n_count = r_count + CW'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_mvalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_merged = r_merged;
                    n_o_wp     = r_wp;
                    n_o_sl     = r_sl;
                    n_o_fence  = (r_status == ST_WAITED) ? r_fence : '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // per-cell operation
    generate
        for (genvar i = 0; i < D; i++) begin : g_cell
            always_comb begin
                unique case (w_chain)
                    CH_POP:  w_op[i] = CELL_NEXT;
                    CH_ROT:  w_op[i] = (CW'(i) == w_last) ? CELL_HEAD : CELL_NEXT;
                    CH_LOAD: w_op[i] = (IW'(i) == w_lsel) ? CELL_LOAD : CELL_HOLD;
                    default: w_op[i] = CELL_HOLD;
                endcase
            end

            frba_cell #(
                .OB(OB)
            ) u_cell (
                .i_clk      (i_clk),
                .i_op       (w_op[i]),
                .i_nbr_id   ((i == D - 1) ? w_id[i] : w_id[(i + 1) % D]),
                .i_nbr_off  ((i == D - 1) ? w_off[i] : w_off[(i + 1) % D]),
                .i_head_id  (w_id[0]),
                .i_head_off (w_off[0]),
                .i_ld_id    (r_cur),
                .i_ld_off   (w_sum[OB-1:0]),
                .o_id       (w_id[i]),
                .o_off      (w_off[i])
            );
        end
    endgenerate

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bsize  <= SIZE_RESET;
            r_wp     <= '0;
            r_sl     <= '0;
            r_cp     <= '0;
            r_count  <= '0;
            r_k      <= '0;
            r_any    <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bsize  <= n_bsize;
            r_wp     <= n_wp;
            r_sl     <= n_sl;
            r_cp     <= n_cp;
            r_count  <= n_count;
            r_k      <= n_k;
            r_any    <= n_any;
            r_mvalid <= n_mvalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_bytes    <= n_bytes;
        r_align    <= n_align;
        r_need     <= n_need;
        r_done     <= n_done;
        r_cur      <= n_cur;
        r_status   <= n_status;
        r_fence    <= n_fence;
        r_merged   <= n_merged;
        r_fmode    <= n_fmode;
        r_o_status <= n_o_status;
        r_o_merged <= n_o_merged;
        r_o_wp     <= n_o_wp;
        r_o_sl     <= n_o_sl;
        r_o_fence  <= n_o_fence;
    end

    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = DW_OUT'({r_o_fence, r_o_sl, r_o_wp});
    assign o_m_axis_tuser  = {r_o_merged, r_o_status};

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CW'(D))
    `ASSERT_IMPLIES(a_search_k, i_clk, i_rst_n, (r_state == S_SEARCH || r_state == S_RESTORE), r_k <= r_count)
    `ASSERT_NEXT(a_result_out, i_clk, i_rst_n, (r_state == S_DONE && w_out_free), o_m_axis_tvalid)
    `ASSERT_IMPLIES(a_commit_action, i_clk, i_rst_n, r_state == S_COMMIT, r_action)

endmodule

`default_nettype wire
